[src/sdc_pkg.sv]
// ----------------------------------------------------------------------------
// sdc_pkg
// shared constants and types for the subset difference counter: table size,
// count modulus and the table memory port bundles
// ----------------------------------------------------------------------------
package sdc_pkg;

    localparam int unsigned MAX_SUM   = 1024;
    localparam int unsigned ADDR_W    = 11;
    localparam int unsigned COUNT_W   = 30;
    localparam int unsigned TABLE_DEP = MAX_SUM + 1;

    typedef logic [ADDR_W-1:0]  t_addr;
    typedef logic [COUNT_W-1:0] t_count;

    localparam t_addr  MAX_ADDR  = t_addr'(MAX_SUM);
    localparam t_addr  OVF_TOTAL = t_addr'(MAX_SUM + 1);
    localparam t_count COUNT_MOD = t_count'(1000000007);

    typedef struct packed {
        logic   en;
        t_addr  addr;
        t_count data;
    } t_ram_wr;

    typedef struct packed {
        logic  en;
        t_addr addr_a;
        t_addr addr_b;
    } t_ram_rd;

endpackage

[src/sdc_mod_add.sv]
// ----------------------------------------------------------------------------
// sdc_mod_add
// adder modulo the count modulus, both operands already reduced
// ----------------------------------------------------------------------------
module sdc_mod_add (
    input  sdc_pkg::t_count i_a,
    input  sdc_pkg::t_count i_b,
    output sdc_pkg::t_count o_sum
);

    logic [sdc_pkg::COUNT_W:0] w_sum;
    logic [sdc_pkg::COUNT_W:0] w_red;

    assign w_sum = {1'b0, i_a} + {1'b0, i_b};
    assign w_red = w_sum - {1'b0, sdc_pkg::COUNT_MOD};

    // sum stays below twice the modulus, so one subtract is enough
    assign o_sum = w_red[sdc_pkg::COUNT_W] ? w_sum[sdc_pkg::COUNT_W-1:0]
                                           : w_red[sdc_pkg::COUNT_W-1:0];

endmodule

[src/sdc_table_ram.sv]
// ----------------------------------------------------------------------------
// sdc_table_ram
// subset count table: one write port, two registered read ports
// ----------------------------------------------------------------------------
module sdc_table_ram (
    input  logic             i_clk,
    input  sdc_pkg::t_ram_wr i_wr,
    input  sdc_pkg::t_ram_rd i_rd,
    output sdc_pkg::t_count  o_rd_a,
    output sdc_pkg::t_count  o_rd_b
);

    sdc_pkg::t_count r_mem [0:sdc_pkg::TABLE_DEP-1];
    sdc_pkg::t_count r_rd_a;
    sdc_pkg::t_count r_rd_b;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd.en) begin
            r_rd_a <= r_mem[i_rd.addr_a];
            r_rd_b <= r_mem[i_rd.addr_b];
        end
    end

    assign o_rd_a = r_rd_a;
    assign o_rd_b = r_rd_b;

endmodule

[src/subset_difference_count_top.sv]
// ----------------------------------------------------------------------------
// subset_difference_count_top: each item walks the table from the top entry down,
// with one read-modify-write of the shared modular adder per table entry;
// a value above 1024 skips the walk. A last item adds a result step and a
// table clear. Reset (synchronous) runs the same table clear.
// ----------------------------------------------------------------------------
module subset_difference_count_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration: difference
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [10:0] i_cfg_data,
    // input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [10:0] value
    input  logic        s_axis_tlast,
    // result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [29:0] count
    output logic        m_axis_tuser    // [0] status
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_WALK  = 3'd1;
    localparam logic [2:0] ST_DRAIN = 3'd2;
    localparam logic [2:0] ST_RES   = 3'd3;
    localparam logic [2:0] ST_RESW  = 3'd4;
    localparam logic [2:0] ST_CLR   = 3'd5;

    logic [2:0]      r_state, n_state;
    sdc_pkg::t_addr  r_addr, n_addr;
    sdc_pkg::t_addr  r_val, n_val;
    logic            r_last, n_last;
    sdc_pkg::t_addr  r_total, n_total;
    logic            r_ovf, n_ovf;
    sdc_pkg::t_addr  r_diff;
    logic            r_wr_en;
    sdc_pkg::t_addr  r_wr_addr;
    logic            r_m_valid, n_m_valid;
    sdc_pkg::t_count r_count, n_count;
    logic            r_status, n_status;

    sdc_pkg::t_ram_wr w_wr;
    sdc_pkg::t_ram_rd w_rd;
    sdc_pkg::t_count  w_rd_a;
    sdc_pkg::t_count  w_rd_b;
    sdc_pkg::t_count  w_mod_sum;

    logic                      w_accept;
    sdc_pkg::t_addr            w_in_val;
    logic [sdc_pkg::ADDR_W:0]  w_acc_sum;
    logic [sdc_pkg::ADDR_W:0]  w_tgt_sum;
    logic                      w_res_ok;
    logic                      w_out_free;

    sdc_table_ram u_table (
        .i_clk  (i_clk),
        .i_wr   (w_wr),
        .i_rd   (w_rd),
        .o_rd_a (w_rd_a),
        .o_rd_b (w_rd_b)
    );

    sdc_mod_add u_add (
        .i_a   (w_rd_a),
        .i_b   (w_rd_b),
        .o_sum (w_mod_sum)
    );

    assign s_axis_tready = (r_state == ST_IDLE);
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_in_val      = s_axis_tdata[sdc_pkg::ADDR_W-1:0];
    assign w_acc_sum     = {1'b0, r_total} + {1'b0, w_in_val};
    assign w_tgt_sum     = {1'b0, r_total} + {1'b0, r_diff};
    assign w_res_ok      = !r_ovf && (r_diff <= r_total) && !w_tgt_sum[0];
    assign w_out_free    = !r_m_valid || m_axis_tready;

    // table read: walk reads entry and entry-value; result reads the target
    always_comb begin
        w_rd.en     = 1'b0;
        w_rd.addr_a = r_addr;
        w_rd.addr_b = r_addr - r_val;
        if (r_state == ST_WALK) begin
            w_rd.en = 1'b1;
        end else if (r_state == ST_RES) begin
            w_rd.en     = 1'b1;
            w_rd.addr_a = w_tgt_sum[sdc_pkg::ADDR_W:1];
        end
    end

    // table write: clear sweep or write-back in the cycle after each walk read
    always_comb begin
        if (r_state == ST_CLR) begin
            w_wr.en   = 1'b1;
            w_wr.addr = r_addr;
            w_wr.data = (r_addr == '0) ? sdc_pkg::t_count'(1) : '0;
        end else begin
            w_wr.en   = r_wr_en;
            w_wr.addr = r_wr_addr;
            w_wr.data = w_mod_sum;
        end
    end

    always_comb begin
        n_state   = r_state;
        n_addr    = r_addr;
        n_val     = r_val;
        n_last    = r_last;
        n_total   = r_total;
        n_ovf     = r_ovf;
        n_m_valid = r_m_valid && !m_axis_tready;
        n_count   = r_count;
        n_status  = r_status;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_val  = w_in_val;
                    n_last = s_axis_tlast;
                    n_addr = sdc_pkg::MAX_ADDR;
                    if (!r_ovf) begin
                        if (w_acc_sum > {1'b0, sdc_pkg::MAX_ADDR}) begin
                            n_ovf   = 1'b1;
                            n_total = sdc_pkg::OVF_TOTAL;
                        end else begin
                            n_total = w_acc_sum[sdc_pkg::ADDR_W-1:0];
                        end
                    end
                    if (w_in_val <= sdc_pkg::MAX_ADDR) begin
                        n_state = ST_WALK;
                    end else if (s_axis_tlast) begin
                        n_state = ST_RES;
                    end
                end
            end
            ST_WALK: begin
                if (r_addr == r_val) begin
                    n_state = ST_DRAIN;
                end else begin
                    n_addr = r_addr - 1'b1;
                end
            end
            ST_DRAIN: begin
                n_state = r_last ? ST_RES : ST_IDLE;
            end
            ST_RES: begin
                n_state = ST_RESW;
            end
            ST_RESW: begin
                if (w_out_free) begin
                    n_m_valid = 1'b1;
                    n_count   = w_res_ok ? w_rd_a : '0;
                    n_status  = r_ovf;
                    n_total   = '0;
                    n_ovf     = 1'b0;
                    n_addr    = '0;
                    n_state   = ST_CLR;
                end
            end
            ST_CLR: begin
                if (r_addr == sdc_pkg::MAX_ADDR) begin
                    n_state = ST_IDLE;
                end else begin
                    n_addr = r_addr + 1'b1;
                end
            end
            default: begin
                n_state = ST_CLR;
                n_addr  = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_CLR;
            r_addr    <= '0;
            r_total   <= '0;
            r_ovf     <= 1'b0;
            r_diff    <= '0;
            r_wr_en   <= 1'b0;
            r_m_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_addr    <= n_addr;
            r_total   <= n_total;
            r_ovf     <= n_ovf;
            r_wr_en   <= (r_state == ST_WALK);
            r_m_valid <= n_m_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                r_diff <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_val     <= n_val;
        r_last    <= n_last;
        r_wr_addr <= r_addr;
        r_count   <= n_count;
        r_status  <= n_status;
    end

    assign o_cfg_ready   = 1'b1;
    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = {{(32 - sdc_pkg::COUNT_W){1'b0}}, r_count};
    assign m_axis_tuser  = r_status;

`ifndef SYNTHESIS
    a_result_from_resw: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(r_state) == ST_RESW)
        else $error("result raised outside the result state");

    a_walk_descends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wr_en && $past(r_wr_en) |-> r_wr_addr == $past(r_wr_addr) - 1'b1)
        else $error("walk write-back addresses not descending");

    a_ovf_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovf |-> r_total == sdc_pkg::OVF_TOTAL)
        else $error("overflow set without saturated total");

    a_clear_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_CLR |-> !w_accept && !r_wr_en)
        else $error("input or write-back during table clear");
`endif

endmodule

[tb/sv/subset_difference_count_top_tb.sv]
// ----------------------------------------------------------------------------
// subset_difference_count_top_tb
// streams sets of values into the subset difference counter with random gaps
// on both sides and checks every partition count and status against a behavioural
// copy of the subset table, or against the row values for typed directed rows;
// the difference register is rewritten between phases and rows while the block is idle
// ----------------------------------------------------------------------------
module subset_difference_count_top_tb;

    localparam int CYCLE_LIMIT   = 8000000;
    localparam int SETTLE_CYCLES = 1100;
    localparam int STALL_CYCLES  = 6000;
    localparam int STALL_AFTER   = 15;
    localparam int N_ROWS        = 22;
    localparam int N_PHASES      = 8;
    localparam int PHASE_ITEMS   = 66;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [10:0] i_cfg_data;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata;   // [10:0] value
    logic        s_axis_tlast;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;   // [29:0] count
    logic        m_axis_tuser;   // [0] status

    typedef struct packed {
        sdc_pkg::t_count count;
        logic            status;
    } t_outcome;

    typedef struct packed {
        logic [10:0]     diff;
        logic [10:0]     value;
        logic            last;
        logic            typed;
        sdc_pkg::t_count count;
        logic            status;
    } t_row;

    // subset counts per sum for the set being streamed
    sdc_pkg::t_count subset_ways [0:sdc_pkg::MAX_SUM];
    int unsigned     set_total;
    bit              set_overflow;
    logic [10:0]     diff_reg;

    t_outcome pending_counts [$];
    int       mismatches;
    int       results_seen;
    int       cycles;
    bit       calm;

    // diff, value, last, typed, count, status
    t_row dir_rows [N_ROWS] = '{
        '{11'd0,    11'd0,    1'b1, 1'b1, 30'd2, 1'b0},  // zero joins either side
        '{11'd0,    11'd1024, 1'b1, 1'b1, 30'd0, 1'b0},
        '{11'd0,    11'd3,    1'b0, 1'b0, 30'd0, 1'b0},
        '{11'd0,    11'd3,    1'b1, 1'b0, 30'd0, 1'b0},
        '{11'd0,    11'd1,    1'b1, 1'b1, 30'd0, 1'b0},  // odd parity
        '{11'd0,    11'd1025, 1'b1, 1'b1, 30'd0, 1'b1},  // value beyond table
        '{11'd0,    11'd2047, 1'b1, 1'b1, 30'd0, 1'b1},
        '{11'd0,    11'd600,  1'b0, 1'b0, 30'd0, 1'b0},
        '{11'd0,    11'd600,  1'b1, 1'b1, 30'd0, 1'b1},  // total beyond table
        '{11'd0,    11'd1024, 1'b0, 1'b0, 30'd0, 1'b0},
        '{11'd0,    11'd0,    1'b1, 1'b0, 30'd0, 1'b0},
        '{11'd0,    11'd0,    1'b0, 1'b0, 30'd0, 1'b0},
        '{11'd0,    11'd0,    1'b0, 1'b0, 30'd0, 1'b0},
        '{11'd0,    11'd0,    1'b1, 1'b1, 30'd8, 1'b0},
        '{11'd1024, 11'd1024, 1'b1, 1'b1, 30'd1, 1'b0},
        '{11'd1024, 11'd5,    1'b1, 1'b1, 30'd0, 1'b0},  // difference above total
        '{11'd2047, 11'd1024, 1'b1, 1'b1, 30'd0, 1'b0},
        '{11'd3,    11'd1,    1'b0, 1'b0, 30'd0, 1'b0},
        '{11'd3,    11'd2,    1'b0, 1'b0, 30'd0, 1'b0},
        '{11'd3,    11'd4,    1'b1, 1'b0, 30'd0, 1'b0},
        '{11'd3,    11'd1024, 1'b0, 1'b0, 30'd0, 1'b0},
        '{11'd3,    11'd1,    1'b1, 1'b1, 30'd0, 1'b1}
    };

    subset_difference_count_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin : clock_gen
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic void clear_ways();
        foreach (subset_ways[i]) subset_ways[i] = '0;
        subset_ways[0] = sdc_pkg::t_count'(1);
        set_total      = 0;
        set_overflow   = 1'b0;
    endfunction

    // in-place walk from the top sum down so each value is used once
    function automatic void fold_in(logic [10:0] v);
        longint sum;
        for (int i = sdc_pkg::MAX_SUM; i >= int'(v); i--) begin
            sum = longint'(subset_ways[i]) + longint'(subset_ways[i - int'(v)]);
            subset_ways[i] = sdc_pkg::t_count'(sum % longint'(sdc_pkg::COUNT_MOD));
        end
        if (!set_overflow) begin
            if (set_total + v > sdc_pkg::MAX_SUM) begin
                set_overflow = 1'b1;
                set_total    = sdc_pkg::MAX_SUM + 1;
            end else begin
                set_total = set_total + v;
            end
        end
    endfunction

    function automatic t_outcome close_set();
        t_outcome    o;
        int unsigned target;
        o.status = set_overflow;
        o.count  = '0;
        if (!set_overflow && diff_reg <= set_total && ((set_total + diff_reg) % 2) == 0) begin
            target = (set_total + diff_reg) / 2;
            if (target <= sdc_pkg::MAX_SUM) begin
                o.count = subset_ways[target];
            end
        end
        clear_ways();
        return o;
    endfunction

    // mostly short gaps, a few long ones
    function automatic int gap_len();
        int r;
        if (calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 20);
        return $urandom_range(40, 300);
    endfunction

    function automatic logic [10:0] pick_value();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10) return 11'd0;
        if (r < 75) return 11'($urandom_range(1, 40));
        if (r < 88) return 11'($urandom_range(41, 1024));
        if (r < 93) return 11'd1024;
        return 11'($urandom_range(1025, 2047));
    endfunction

    function automatic logic [10:0] phase_diff(int p);
        case (p)
            0: return 11'd0;
            2: return 11'd1024;
            4: return 11'($urandom_range(0, 2047));
            5: return 11'($urandom_range(0, 7));
            6: return 11'd1;
            7: return 11'($urandom_range(0, 1024));
            default: return 11'($urandom_range(0, 15));
        endcase
    endfunction

    task automatic send_item(input logic [10:0] v, input logic l, input logic typed,
                             input t_outcome given);
        t_outcome o;
        repeat (gap_len()) begin
            @(negedge i_clk);
            s_axis_tvalid = 1'b0;
        end
        @(negedge i_clk);
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = {5'd0, v};
        s_axis_tlast  = l;
        do @(posedge i_clk); while (!s_axis_tready);
        fold_in(v);
        if (l) begin
            o = close_set();
            pending_counts.push_back(typed ? given : o);
        end
    endtask

    // the block must be idle, table clear included, before the register moves
    task automatic set_difference(input logic [10:0] d);
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        while (pending_counts.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_data  = d;
        do @(posedge i_clk); while (!o_cfg_ready);
        diff_reg = d;
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    initial begin : stimulus
        t_outcome given;
        int       items;
        int       len;
        i_rst_n       = 1'b0;
        i_cfg_valid   = 1'b0;
        i_cfg_data    = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tlast  = 1'b0;
        mismatches    = 0;
        results_seen  = 0;
        calm          = 1'b0;
        diff_reg      = '0;
        clear_ways();
        repeat (7) @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (dir_rows[k]) begin
            if (dir_rows[k].diff != diff_reg) set_difference(dir_rows[k].diff);
            given.count  = dir_rows[k].count;
            given.status = dir_rows[k].status;
            send_item(dir_rows[k].value, dir_rows[k].last, dir_rows[k].typed, given);
        end

        for (int p = 0; p < N_PHASES; p++) begin
            calm = (p % 3 == 2);
            set_difference(phase_diff(p));
            items = 0;
            while (items < PHASE_ITEMS) begin
                len = $urandom_range(1, 8);
                for (int j = 0; j < len; j++) begin
                    send_item(pick_value(), j == len - 1, 1'b0, '0);
                end
                items = items + len;
            end
        end

        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        while (pending_counts.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        if (mismatches == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    // result side: random stalls, and one long hold-off so the block backs up
    initial begin : result_sink
        int gap_left;
        int hold_left;
        int seen;
        bit pressed;
        gap_left      = 0;
        hold_left     = 0;
        seen          = 0;
        pressed       = 1'b0;
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (seen != results_seen) begin
                seen     = results_seen;
                gap_left = gap_len();
            end
            if (!pressed && results_seen >= STALL_AFTER) begin
                pressed   = 1'b1;
                hold_left = STALL_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready = 1'b0;
            end else if (gap_left > 0) begin
                gap_left--;
                m_axis_tready = 1'b0;
            end else begin
                m_axis_tready = 1'b1;
            end
        end
    end

    initial begin : result_check
        t_outcome want;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
                results_seen++;
                if (pending_counts.size() == 0) begin
                    $display("%0t unexpected transaction: count %0d status %0b",
                             $time, m_axis_tdata[29:0], m_axis_tuser);
                    mismatches++;
                end else begin
                    want = pending_counts.pop_front();
                    if (m_axis_tdata[29:0] !== want.count) begin
                        $display("%0t count: expected %0d, actual %0d",
                                 $time, want.count, m_axis_tdata[29:0]);
                        mismatches++;
                    end
                    if (m_axis_tuser !== want.status) begin
                        $display("%0t status: expected %0b, actual %0b",
                                 $time, want.status, m_axis_tuser);
                        mismatches++;
                    end
                end
            end
        end
    end

    // timeout
    initial begin : watchdog
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

[subset_difference_count_top.f]
src/sdc_pkg.sv
src/sdc_mod_add.sv
src/sdc_table_ram.sv
src/subset_difference_count_top.sv
tb/sv/subset_difference_count_top_tb.sv
